/* rtl/core/lcatc_pkg.sv */
package lcatc_pkg;

	// fixed by the cell number fields of the stream items
	localparam int CELL_W    = 12;
	localparam int NUM_CELLS = 4096;
	localparam int CNT_W     = 13;

	typedef logic [CELL_W-1:0] cell_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	typedef enum logic {
		FUNC_ALLOC   = 1'b0,
		FUNC_RELEASE = 1'b1
	} func_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_WSTART,
		ST_WSTEP,
		ST_POST,
		ST_DONE
	} state_t;

	// what the current link walk is for
	typedef enum logic [2:0] {
		PH_BIG_ALLOC,
		PH_REFILL,
		PH_ALLOC,
		PH_REL_BIG,
		PH_REL_TAIL,
		PH_SPILL
	} phase_t;

endpackage

/* rtl/core/linked_cell_allocator_thread_cache_core.sv */
// allocate: the thread list may first be refilled from the shared list
// release: the thread list may afterwards spill when it overflows
// one item at a time; each link walked is read through the
// single read port of the next-pointer memory, shared by every walk
// reset: asynchronous, active low; afterwards a clearing pass fills the
// pointer memory with i plus one, and no item is accepted during it
module linked_cell_allocator_thread_cache_core
	import lcatc_pkg::*;
#(
	parameter int NUM_THREADS  = 4,
	parameter int REFILL_CELLS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// thread[1:0], cell_count_req[14:2], chain_start[26:15], zero pad
	input  logic [31:0] s_tdata,
	// func
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// chain_head[11:0], out_of_cells[12], zero pad
	output logic [15:0] m_tdata
);

	localparam int TW = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
	localparam cnt_t BS_C = CNT_W'(REFILL_CELLS);
	localparam logic [CNT_W:0] BS2_C = (CNT_W+1)'(2 * REFILL_CELLS);

	// next-pointer memory, one read and one write port
	cell_t mem_q [NUM_CELLS];
	cell_t rd_q;
	cell_t rd_addr;
	logic  we;
	cell_t wa;
	cell_t wd;

	state_t state_q, state_d;
	phase_t phase_q;
	cell_t  clr_q;

	// captured request
	logic          func_q;
	logic [TW-1:0] thr_q;
	logic          thr_ok_q;
	cnt_t          n_q;
	cell_t         start_q;

	// allocator state
	cell_t sh_q;
	cell_t st_q;
	cell_t ph_q [NUM_THREADS];
	cell_t pt_q [NUM_THREADS];
	cnt_t  pf_q [NUM_THREADS];

	// walk unit
	cell_t cur_q;
	cell_t prv_q;
	cnt_t  cnt_q;
	cnt_t  k_q;
	logic  flag_en_q;

	logic  flag_q;
	cell_t res_head_q;

	logic  out_valid_q;
	cell_t out_head_q;
	logic  out_flag_q;

	// decode decisions, valid in ST_DECODE and ST_POST
	cnt_t fr;
	logic big_alloc, need_refill, big_rel, spill_need;

	always_comb begin
		fr          = pf_q[thr_q];
		need_refill = {1'b0, fr} < ({1'b0, n_q} + (CNT_W+1)'(2));
		big_alloc   = (n_q > BS_C) && need_refill;
		big_rel     = (n_q > BS_C) && (({1'b0, fr} + {1'b0, n_q}) >= BS2_C);
		spill_need  = {1'b0, fr} >= BS2_C;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:  if (clr_q == cell_t'(NUM_CELLS - 1)) state_d = ST_IDLE;
			ST_IDLE:   if (s_tvalid) state_d = ST_DECODE;
			ST_DECODE: state_d = thr_ok_q ? ST_WSTART : ST_DONE;
			ST_WSTART: state_d = (k_q == '0) ? ST_POST : ST_WSTEP;
			ST_WSTEP:  if (cnt_q + cnt_t'(1) == k_q) state_d = ST_POST;
			ST_POST: begin
				unique case (phase_q)
					PH_REFILL:   state_d = ST_WSTART;
					PH_REL_TAIL: state_d = spill_need ? ST_WSTART : ST_DONE;
					default:     state_d = ST_DONE;
				endcase
			end
			ST_DONE:   if (!out_valid_q || m_tready) state_d = ST_IDLE;
			default:   state_d = ST_CLEAR;
		endcase
	end

	// outputs of the sequencer: handshake, memory ports
	always_comb begin
		s_tready = (state_q == ST_IDLE);
		rd_addr  = (state_q == ST_WSTART) ? cur_q : rd_q;
		we       = 1'b0;
		wa       = st_q;
		wd       = start_q;
		unique case (state_q)
			ST_CLEAR: begin
				we = 1'b1;
				wa = clr_q;
				wd = clr_q + cell_t'(1);
			end
			ST_DECODE: begin
				if (thr_ok_q) begin
					wa = pt_q[thr_q];
					if (func_q == FUNC_ALLOC) begin
						// refill: private tail links to the shared head
						we = need_refill && !big_alloc;
						wd = sh_q;
					end else begin
						we = !big_rel;
						wd = start_q;
					end
				end
			end
			ST_POST: begin
				// shared tail links to the released or spilled chain
				we = (phase_q == PH_REL_BIG) || (phase_q == PH_SPILL);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem_q[wa] <= wd;
		rd_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			phase_q     <= PH_ALLOC;
			clr_q       <= '0;
			sh_q        <= cell_t'(NUM_THREADS * REFILL_CELLS);
			st_q        <= cell_t'(NUM_CELLS - 1);
			for (int t = 0; t < NUM_THREADS; t++) begin
				ph_q[t] <= cell_t'(t * REFILL_CELLS);
				pt_q[t] <= cell_t'(t * REFILL_CELLS + REFILL_CELLS - 1);
				pf_q[t] <= BS_C;
			end
			out_valid_q <= 1'b0;
			flag_q      <= 1'b0;
			res_head_q  <= '0;
			cur_q       <= '0;
			prv_q       <= '0;
			cnt_q       <= '0;
			k_q         <= '0;
			flag_en_q   <= 1'b0;
			func_q      <= 1'b0;
			thr_q       <= '0;
			thr_ok_q    <= 1'b0;
			n_q         <= '0;
			start_q     <= '0;
			out_head_q  <= '0;
			out_flag_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (m_tvalid && m_tready && state_q != ST_DONE) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: clr_q <= clr_q + cell_t'(1);
				ST_IDLE: begin
					if (s_tvalid) begin
						func_q   <= s_tuser;
						thr_q    <= TW'(s_tdata[1:0]);
						thr_ok_q <= {3'b000, s_tdata[1:0]} < 5'(NUM_THREADS);
						n_q      <= s_tdata[14:2];
						start_q  <= s_tdata[26:15];
					end
				end
				ST_DECODE: begin
					flag_q     <= 1'b0;
					res_head_q <= '0;
					if (thr_ok_q) begin
						if (func_q == FUNC_ALLOC) begin
							if (big_alloc) begin
								phase_q    <= PH_BIG_ALLOC;
								res_head_q <= sh_q;
								cur_q      <= sh_q;
								k_q        <= n_q;
								flag_en_q  <= 1'b1;
							end else if (need_refill) begin
								phase_q       <= PH_REFILL;
								pf_q[thr_q]   <= fr + BS_C;
								cur_q         <= sh_q;
								k_q           <= BS_C;
								flag_en_q     <= 1'b1;
							end else begin
								phase_q       <= PH_ALLOC;
								res_head_q    <= ph_q[thr_q];
								pf_q[thr_q]   <= fr - n_q;
								cur_q         <= ph_q[thr_q];
								k_q           <= n_q;
								flag_en_q     <= 1'b0;
							end
						end else begin
							flag_en_q <= 1'b0;
							if (big_rel) begin
								phase_q <= PH_REL_BIG;
								cur_q   <= start_q;
								k_q     <= n_q - cnt_t'(1);
							end else begin
								phase_q     <= PH_REL_TAIL;
								pf_q[thr_q] <= fr + n_q;
								cur_q       <= pt_q[thr_q];
								k_q         <= n_q;
							end
						end
					end
				end
				ST_WSTART: cnt_q <= '0;
				ST_WSTEP: begin
					prv_q <= cur_q;
					cur_q <= rd_q;
					cnt_q <= cnt_q + cnt_t'(1);
					if (flag_en_q && rd_q == st_q) flag_q <= 1'b1;
				end
				ST_POST: begin
					unique case (phase_q)
						PH_BIG_ALLOC: sh_q <= cur_q;
						PH_REFILL: begin
							pt_q[thr_q] <= prv_q;
							sh_q        <= cur_q;
							// now take the cells from the refilled thread list
							phase_q     <= PH_ALLOC;
							res_head_q  <= ph_q[thr_q];
							pf_q[thr_q] <= fr - n_q;
							cur_q       <= ph_q[thr_q];
							k_q         <= n_q;
							flag_en_q   <= 1'b0;
						end
						PH_ALLOC: ph_q[thr_q] <= cur_q;
						PH_REL_BIG: st_q <= cur_q;
						PH_REL_TAIL: begin
							pt_q[thr_q] <= cur_q;
							if (spill_need) begin
								phase_q <= PH_SPILL;
								start_q <= ph_q[thr_q];
								cur_q   <= ph_q[thr_q];
								k_q     <= fr - BS_C;
							end
						end
						PH_SPILL: begin
							ph_q[thr_q] <= cur_q;
							pf_q[thr_q] <= BS_C;
							st_q        <= prv_q;
						end
						default: ;
					endcase
				end
				ST_DONE: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						out_head_q  <= res_head_q;
						out_flag_q  <= flag_q;
					end
				end
				default: ;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_flag_q, out_head_q};

`ifndef SYNTHESIS
	// a new result only ever comes from the done state
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside done state");

	// an accepted item is decoded in the next cycle
	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_DECODE))
		else $error("accepted item not decoded");

	// the walk never runs past its step count
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WSTEP) |-> (cnt_q < k_q))
		else $error("walk overran its count");

	// a spill leaves the thread list at one block
	a_spill_level: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POST && phase_q == PH_SPILL) |=> (pf_q[thr_q] == BS_C))
		else $error("spill left wrong free count");
`endif

endmodule
